FILE: src/wca_pkg.sv
// shared types and constants of the weighted centroid accumulator
// command codes, payload structs and controller/datapath interface structs
// no dependencies
package wca_pkg;

   // sizes
   localparam int MAX_DIMS = 64;
   localparam int DIM_W    = $clog2(MAX_DIMS);
   localparam int DIMS_W   = 7;
   localparam int VAL_W    = 32;
   localparam int WGT_W    = 16;
   localparam int SUM_W    = 64;
   localparam int TOT_W    = 32;
   localparam int PROD_W   = VAL_W + WGT_W;
   localparam int STEP_W   = $clog2(SUM_W);
   localparam int CMD_W    = 3;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_VOTE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FINALIZE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

   // register map, index taken from the word address bit
   localparam logic REG_DIMS_IN_USE = 1'b0;
   localparam logic [DIMS_W-1:0] DIMS_RESET = 7'd64;

   // input item
   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [DIM_W-1:0]        dim_index;
      logic signed [VAL_W-1:0] value;
      logic                    value_missing;
      logic [WGT_W-1:0]        weight;
   } req_type;

   // result item
   typedef struct packed {
      logic signed [VAL_W-1:0] center_value;
      logic                    center_missing;
      logic [DIM_W-1:0]        out_dim;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic clear_valid;
      logic acc_write;
      logic div_load;
      logic div_step;
      logic fin_write;
      logic load_write;
      logic emit_read;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tot_zero;
   } ctrl_status_type;

endpackage

FILE: src/wca_datapath.sv
// datapath of the weighted centroid accumulator: sum, total and center stores,
// vote multiply and saturating add, bit-serial divider, result register
// depends on wca_pkg
module wca_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  wca_pkg::req_type               req_data,
   input  logic [wca_pkg::DIMS_W-1:0]     dims_in_use,
   input  wca_pkg::ctrl_cmd_type          cmd,
   output wca_pkg::ctrl_status_type       status,
   output logic                           rsp_strobe,
   output wca_pkg::rsp_type               rsp_data
);

   // latched item
   logic [wca_pkg::DIM_W-1:0]        dim_ff;
   logic signed [wca_pkg::VAL_W-1:0] value_ff;
   logic                             miss_ff;
   logic [wca_pkg::WGT_W-1:0]        weight_ff;

   // stores
   logic [wca_pkg::SUM_W-1:0] sum_mem [wca_pkg::MAX_DIMS];
   logic [wca_pkg::TOT_W-1:0] tot_mem [wca_pkg::MAX_DIMS];
   logic [wca_pkg::VAL_W-1:0] cen_mem [wca_pkg::MAX_DIMS];
   logic [wca_pkg::SUM_W-1:0] sum_rd_ff;
   logic [wca_pkg::TOT_W-1:0] tot_rd_ff;
   logic [wca_pkg::VAL_W-1:0] cen_rd_ff;
   logic [wca_pkg::MAX_DIMS-1:0] valid_ff, valid_in;
   logic [wca_pkg::MAX_DIMS-1:0] mark_ff, mark_in;
   logic [wca_pkg::MAX_DIMS-1:0] clr_mask;

   // vote arithmetic
   logic signed [wca_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [wca_pkg::SUM_W-1:0] sum_cur, prod_ext, sum_raw, sum_new;
   logic [wca_pkg::TOT_W-1:0] tot_cur, tot_new;
   logic [wca_pkg::TOT_W:0]   tot_raw;
   logic                      sum_ovf;

   // divider
   logic                      sign_ff;
   logic [wca_pkg::TOT_W-1:0] rem_ff, rem_in;
   logic [wca_pkg::SUM_W-1:0] quo_ff, quo_in;
   logic [wca_pkg::TOT_W:0]   rem_sh;
   logic [wca_pkg::TOT_W+1:0] rem_diff;
   logic [wca_pkg::VAL_W-1:0] q_pos, q_neg, fin_value;

   // result register
   logic                  rsp_strobe_ff, rsp_strobe_in;
   wca_pkg::rsp_type      rsp_ff, rsp_in;

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dim_ff    <= req_data.dim_index;
         value_ff  <= req_data.value;
         miss_ff   <= req_data.value_missing;
         weight_ff <= req_data.weight;
      end
   end

   // multiplier, registered before the add
   assign prod_in =
      $signed({{(wca_pkg::PROD_W - wca_pkg::VAL_W){value_ff[wca_pkg::VAL_W-1]}}, value_ff}) *
      $signed({{(wca_pkg::PROD_W - wca_pkg::WGT_W){1'b0}}, weight_ff});
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // entries not yet written since clear read as zero
   assign sum_cur = valid_ff[dim_ff] ? sum_rd_ff : '0;
   assign tot_cur = valid_ff[dim_ff] ? tot_rd_ff : '0;
   assign status.tot_zero = (tot_cur == '0);

   // saturating accumulate
   always_comb begin
      prod_ext = {{(wca_pkg::SUM_W - wca_pkg::PROD_W){prod_ff[wca_pkg::PROD_W-1]}}, prod_ff};
      sum_raw  = sum_cur + prod_ext;
      sum_ovf  = (sum_cur[wca_pkg::SUM_W-1] == prod_ext[wca_pkg::SUM_W-1]) &&
                 (sum_raw[wca_pkg::SUM_W-1] != sum_cur[wca_pkg::SUM_W-1]);
      if (sum_ovf) begin
         sum_new = sum_cur[wca_pkg::SUM_W-1] ? {1'b1, {(wca_pkg::SUM_W-1){1'b0}}}
                                             : {1'b0, {(wca_pkg::SUM_W-1){1'b1}}};
      end else begin
         sum_new = sum_raw;
      end
      tot_raw = {1'b0, tot_cur} + {{(wca_pkg::TOT_W - wca_pkg::WGT_W + 1){1'b0}}, weight_ff};
      tot_new = tot_raw[wca_pkg::TOT_W] ? '1 : tot_raw[wca_pkg::TOT_W-1:0];
   end

   // sum and total stores
   always_ff @(posedge clock) begin
      if (cmd.acc_write) begin
         sum_mem[dim_ff] <= sum_new;
         tot_mem[dim_ff] <= tot_new;
      end
      sum_rd_ff <= sum_mem[dim_ff];
      tot_rd_ff <= tot_mem[dim_ff];
   end

   // clear walks the dimensions below dims_in_use at once through the valid bits
   always_comb begin
      for (int i = 0; i < wca_pkg::MAX_DIMS; i++) begin
         clr_mask[i] = (wca_pkg::DIMS_W'(i) < dims_in_use);
      end
      valid_in = valid_ff;
      if (cmd.clear_valid) begin
         valid_in = valid_ff & ~clr_mask;
      end else if (cmd.acc_write) begin
         valid_in[dim_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mark_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         mark_ff  <= mark_in;
      end
   end

   // missing marks
   always_comb begin
      mark_in = mark_ff;
      if (cmd.load_write) begin
         mark_in[dim_ff] = miss_ff;
      end else if (cmd.fin_write) begin
         mark_in[dim_ff] = status.tot_zero;
      end
   end

   // restoring divider step, one quotient bit a cycle
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[wca_pkg::SUM_W-1]};
      rem_diff = {1'b0, rem_sh} - {2'b00, tot_cur};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (cmd.div_load) begin
         rem_in = '0;
         quo_in = sum_cur[wca_pkg::SUM_W-1] ? (wca_pkg::SUM_W'(0) - sum_cur) : sum_cur;
      end else if (cmd.div_step) begin
         if (!rem_diff[wca_pkg::TOT_W+1]) begin
            rem_in = rem_diff[wca_pkg::TOT_W-1:0];
            quo_in = {quo_ff[wca_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[wca_pkg::TOT_W-1:0];
            quo_in = {quo_ff[wca_pkg::SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.div_load) begin
         sign_ff <= sum_cur[wca_pkg::SUM_W-1];
      end
   end

   // quotient saturation to signed 32 bits
   always_comb begin
      q_pos = (|quo_ff[wca_pkg::SUM_W-1:wca_pkg::VAL_W-1]) ? 32'h7FFF_FFFF
                                                            : quo_ff[wca_pkg::VAL_W-1:0];
      q_neg = ((|quo_ff[wca_pkg::SUM_W-1:wca_pkg::VAL_W]) ||
               (quo_ff[wca_pkg::VAL_W-1] && (|quo_ff[wca_pkg::VAL_W-2:0])))
              ? 32'h8000_0000 : quo_ff[wca_pkg::VAL_W-1:0];
      if (status.tot_zero) begin
         fin_value = '0;
      end else if (sign_ff) begin
         fin_value = wca_pkg::VAL_W'(0) - q_neg;
      end else begin
         fin_value = q_pos;
      end
   end

   // center store
   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         cen_mem[dim_ff] <= miss_ff ? '0 : value_ff;
      end else if (cmd.fin_write) begin
         cen_mem[dim_ff] <= fin_value;
      end
      cen_rd_ff <= cen_mem[dim_ff];
   end

   // result register
   always_comb begin
      rsp_strobe_in = cmd.fin_write | cmd.emit_read;
      rsp_in.out_dim = dim_ff;
      if (cmd.fin_write) begin
         rsp_in.center_value   = fin_value;
         rsp_in.center_missing = status.tot_zero;
      end else begin
         rsp_in.center_value   = mark_ff[dim_ff] ? '0 : cen_rd_ff;
         rsp_in.center_missing = mark_ff[dim_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: src/wca_ctrl.sv
// controller of the weighted centroid accumulator: command sequencing,
// divider step count and datapath commands
// depends on wca_pkg
module wca_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  wca_pkg::req_type            req_data,
   input  wca_pkg::ctrl_status_type    status,
   output logic                        busy,
   output wca_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOAD,
      ST_FETCH,
      ST_ACC,
      ST_DIV_INIT,
      ST_DIV,
      ST_FIN,
      ST_EMIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [wca_pkg::CMD_W-1:0]   op_ff, op_in;
   logic [wca_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic                        accept;

   assign accept = start && (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in = req_data.command;
               unique case (req_data.command)
                  wca_pkg::CMD_CLEAR:    state_in = ST_CLEAR;
                  wca_pkg::CMD_VOTE:     state_in = req_data.value_missing ? ST_IDLE : ST_FETCH;
                  wca_pkg::CMD_FINALIZE: state_in = ST_FETCH;
                  wca_pkg::CMD_READ:     state_in = ST_FETCH;
                  wca_pkg::CMD_LOAD:     state_in = ST_LOAD;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: begin
            unique case (op_ff)
               wca_pkg::CMD_VOTE:     state_in = ST_ACC;
               wca_pkg::CMD_FINALIZE: state_in = ST_DIV_INIT;
               default:               state_in = ST_EMIT;
            endcase
         end
         ST_DIV_INIT: begin
            cnt_in   = '0;
            state_in = status.tot_zero ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_FIN;
            end
         end
         ST_CLEAR, ST_LOAD, ST_ACC, ST_FIN, ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= wca_pkg::CMD_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
      end
   end

   // datapath commands
   always_comb begin
      cmd.capture     = accept;
      cmd.clear_valid = (state_ff == ST_CLEAR);
      cmd.acc_write   = (state_ff == ST_ACC);
      cmd.div_load    = (state_ff == ST_DIV_INIT);
      cmd.div_step    = (state_ff == ST_DIV);
      cmd.fin_write   = (state_ff == ST_FIN);
      cmd.load_write  = (state_ff == ST_LOAD);
      cmd.emit_read   = (state_ff == ST_EMIT);
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: src/weighted_centroid_accumulator.sv
// weighted centroid accumulator top level: configuration port, controller, datapath
// one item at a time; cycles per item: clear 2, load 2, vote 3 (1 when missing),
// read 3 with the result transfer 3 cycles after the input transfer, finalize 68 with
// the result transfer 68 cycles after (4 when the total is zero), set by the 64-step divider
// synchronous active-high reset clears the valid bits so sums and totals read zero,
// clears the missing marks and sets dims_in_use to 64; results cannot be stalled
module weighted_centroid_accumulator (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          start,
   output logic                          busy,
   input  wca_pkg::req_type              req_data,
   // result channel
   output logic                          rsp_strobe,
   output wca_pkg::rsp_type              rsp_data,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [wca_pkg::ADDR_W-1:0]    paddr,
   input  logic [wca_pkg::DATA_W-1:0]    pwdata,
   output logic [wca_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   logic [wca_pkg::DIMS_W-1:0]   dims_ff, dims_in;
   logic                         cfg_write;
   wca_pkg::ctrl_cmd_type        cmd;
   wca_pkg::ctrl_status_type     status;

   // register write on the access cycle of a transfer
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready &&
                      (paddr[wca_pkg::ADDR_W-1] == wca_pkg::REG_DIMS_IN_USE);
   assign dims_in   = cfg_write ? pwdata[wca_pkg::DIMS_W-1:0] : dims_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= wca_pkg::DIMS_RESET;
      end else begin
         dims_ff <= dims_in;
      end
   end

   // register read
   assign prdata = (paddr[wca_pkg::ADDR_W-1] == wca_pkg::REG_DIMS_IN_USE)
                   ? {{(wca_pkg::DATA_W - wca_pkg::DIMS_W){1'b0}}, dims_ff} : '0;

   wca_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   wca_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .dims_in_use (dims_ff),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the weighted centroid accumulator: directed and random commands,
// in-bench center predictor, csr writes of dims_in_use between phases
// depends on wca_pkg and weighted_centroid_accumulator
module testbench;

   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 500000;
   localparam logic [wca_pkg::ADDR_W-1:0] DIMS_ADDR = {wca_pkg::REG_DIMS_IN_USE, 2'b00};

   typedef enum logic [1:0] {STEP_ITEM, STEP_PAUSE, STEP_CSR} step_kind_type;
   typedef struct {
      step_kind_type                 kind;
      wca_pkg::req_type              item;
      logic [wca_pkg::DATA_W-1:0]    csr_value;
   } plan_step_type;

   typedef enum logic [2:0] {
      DRV_IDLE, DRV_GAP, DRV_START, DRV_DRAIN, DRV_SETTLE, DRV_SETUP, DRV_ACCESS
   } drv_state_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   wca_pkg::req_type              req_data;
   logic                          rsp_strobe;
   wca_pkg::rsp_type              rsp_data;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [wca_pkg::ADDR_W-1:0]    paddr;
   logic [wca_pkg::DATA_W-1:0]    pwdata;
   logic [wca_pkg::DATA_W-1:0]    prdata;
   logic                          pready;

   // predictor state
   logic [wca_pkg::SUM_W-1:0]  vote_sums   [wca_pkg::MAX_DIMS];
   logic [wca_pkg::TOT_W-1:0]  vote_totals [wca_pkg::MAX_DIMS];
   logic [wca_pkg::VAL_W-1:0]  center_vals [wca_pkg::MAX_DIMS];
   logic                       center_marks[wca_pkg::MAX_DIMS];
   logic [wca_pkg::DIMS_W-1:0] dims_cfg;

   // which center elements the plan has written so far
   bit                center_written[wca_pkg::MAX_DIMS];

   plan_step_type     cmd_plan[$];
   wca_pkg::rsp_type  center_expected[$];
   plan_step_type     cur_step;
   drv_state_type     drv_state;
   int                gap_left;
   int                settle_left;
   bit                no_gaps;
   logic              req_taken;
   logic              csr_taken;
   int                error_count;
   int                cycle_count;

   weighted_centroid_accumulator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // applies one accepted command to the predictor, returns 1 when it emits a center element
   function automatic bit predict_center(input wca_pkg::req_type r, output wca_pkg::rsp_type o);
      logic [63:0] prod;
      logic [63:0] mag;
      logic [63:0] quot;
      logic [64:0] wide;
      logic [32:0] tot;
      logic        neg;
      int          n;
      int          d;
      o = '0;
      d = int'(r.dim_index);
      case (r.command)
         wca_pkg::CMD_CLEAR: begin
            n = (dims_cfg > wca_pkg::MAX_DIMS) ? wca_pkg::MAX_DIMS : int'(dims_cfg);
            for (int i = 0; i < n; i++) begin
               vote_sums[i]   = '0;
               vote_totals[i] = '0;
            end
            return 1'b0;
         end
         wca_pkg::CMD_VOTE: begin
            if (!r.value_missing) begin
               prod = $signed({{32{r.value[31]}}, r.value}) * $signed({48'd0, r.weight});
               wide = {vote_sums[d][63], vote_sums[d]} + {prod[63], prod};
               // saturate at the signed 64-bit limits
               if (wide[64] != wide[63])
                  vote_sums[d] = wide[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
               else
                  vote_sums[d] = wide[63:0];
               tot = {1'b0, vote_totals[d]} + {17'd0, r.weight};
               vote_totals[d] = tot[32] ? 32'hFFFF_FFFF : tot[31:0];
            end
            return 1'b0;
         end
         wca_pkg::CMD_LOAD: begin
            center_vals[d]  = r.value_missing ? '0 : r.value;
            center_marks[d] = r.value_missing;
            return 1'b0;
         end
         wca_pkg::CMD_FINALIZE: begin
            if (vote_totals[d] != 0) begin
               // sign-magnitude divide, truncation toward zero
               neg  = vote_sums[d][63];
               mag  = neg ? (64'd0 - vote_sums[d]) : vote_sums[d];
               quot = mag / {32'd0, vote_totals[d]};
               if (!neg) begin
                  center_vals[d] = (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
               end else begin
                  if (quot > 64'h8000_0000) quot = 64'h8000_0000;
                  center_vals[d] = 32'd0 - quot[31:0];
               end
               center_marks[d] = 1'b0;
            end else begin
               center_vals[d]  = '0;
               center_marks[d] = 1'b1;
            end
         end
         wca_pkg::CMD_READ: ;
         default: return 1'b0;
      endcase
      o.center_value   = center_marks[d] ? '0 : center_vals[d];
      o.center_missing = center_marks[d];
      o.out_dim        = r.dim_index;
      return 1'b1;
   endfunction

   task automatic add_cmd(input logic [wca_pkg::CMD_W-1:0] cmd, input int dim,
                          input logic [wca_pkg::VAL_W-1:0] value, input logic miss,
                          input logic [wca_pkg::WGT_W-1:0] weight);
      plan_step_type s;
      s.kind               = STEP_ITEM;
      s.csr_value          = '0;
      s.item.command       = cmd;
      s.item.dim_index     = dim[wca_pkg::DIM_W-1:0];
      s.item.value         = value;
      s.item.value_missing = miss;
      s.item.weight        = weight;
      if (cmd == wca_pkg::CMD_LOAD || cmd == wca_pkg::CMD_FINALIZE) center_written[dim] = 1'b1;
      cmd_plan.push_back(s);
   endtask

   task automatic add_hold(input step_kind_type kind, input logic [wca_pkg::DATA_W-1:0] value);
      plan_step_type s;
      s.kind      = kind;
      s.item      = '0;
      s.csr_value = value;
      cmd_plan.push_back(s);
   endtask

   // one random command or pause, mostly votes on a few busy dimensions
   task automatic add_random_cmd();
      int                          sel;
      int                          dim;
      logic [31:0]                 rnd;
      logic [wca_pkg::VAL_W-1:0]   value;
      logic [wca_pkg::WGT_W-1:0]   weight;
      sel = int'($urandom_range(0, 99));
      dim = int'(($urandom_range(0, 3) == 0) ? $urandom_range(0, wca_pkg::MAX_DIMS - 1)
                                             : $urandom_range(0, 7));
      case ($urandom_range(0, 9))
         0:       value = 32'h7FFF_FFFF;
         1:       value = 32'h8000_0000;
         2, 3:    value = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         default: value = $urandom;
      endcase
      rnd = $urandom;
      case ($urandom_range(0, 9))
         0:       weight = '0;
         1:       weight = '1;
         default: weight = rnd[wca_pkg::WGT_W-1:0];
      endcase
      if (sel < 58)
         add_cmd(wca_pkg::CMD_VOTE, dim, value, $urandom_range(0, 9) == 0, weight);
      else if (sel < 70)
         add_cmd(wca_pkg::CMD_FINALIZE, dim, value, $urandom_range(0, 1) == 1, weight);
      else if (sel < 80)
         add_cmd(center_written[dim] ? wca_pkg::CMD_READ : wca_pkg::CMD_FINALIZE, dim, value,
                 $urandom_range(0, 1) == 1, weight);
      else if (sel < 90)
         add_cmd(wca_pkg::CMD_LOAD, dim, value, $urandom_range(0, 3) == 0, weight);
      else if (sel < 95)
         add_cmd(wca_pkg::CMD_CLEAR, dim, value, $urandom_range(0, 1) == 1, weight);
      else if (sel < 98) begin
         rnd = wca_pkg::CMD_READ + $urandom_range(1, 3);
         add_cmd(rnd[wca_pkg::CMD_W-1:0], dim, value, $urandom_range(0, 1) == 1, weight);
      end else
         add_hold(STEP_PAUSE, '0);
   endtask

   // stimulus plan, reset and end of run
   initial begin
      logic [wca_pkg::DIMS_W-1:0] phase_dims[6];
      logic [31:0]                rnd;
      reset   = 1'b1;
      start   = 1'b0;
      req_data = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      for (int i = 0; i < wca_pkg::MAX_DIMS; i++) begin
         vote_sums[i]      = '0;
         vote_totals[i]    = '0;
         center_vals[i]    = '0;
         center_marks[i]   = 1'b0;
         center_written[i] = 1'b0;
      end
      dims_cfg = wca_pkg::DIMS_RESET;

      // directed: field extremes, every command, special cases
      add_hold(STEP_CSR, 32'd64);
      add_cmd(wca_pkg::CMD_VOTE, 0, 32'h8000_0000, 1'b0, 16'hFFFF);
      add_cmd(wca_pkg::CMD_VOTE, 0, 32'h7FFF_FFFF, 1'b0, 16'h0001);
      add_cmd(wca_pkg::CMD_VOTE, 63, 32'h7FFF_FFFF, 1'b0, 16'hFFFF);
      add_cmd(wca_pkg::CMD_VOTE, 63, 32'h8000_0000, 1'b1, 16'hFFFF);   // missing value skipped
      add_cmd(wca_pkg::CMD_VOTE, 2, 32'h0001_2345, 1'b0, 16'h0000);    // zero weight
      add_cmd(wca_pkg::CMD_VOTE, 1, 32'hFFFF_FFFD, 1'b0, 16'h0001);
      add_cmd(wca_pkg::CMD_VOTE, 1, 32'h0000_0000, 1'b0, 16'h0001);    // -1.5 lsb truncates to -1
      add_cmd(wca_pkg::CMD_FINALIZE, 0, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_FINALIZE, 63, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_FINALIZE, 1, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_FINALIZE, 2, '0, 1'b0, '0);                 // zero total
      add_cmd(wca_pkg::CMD_FINALIZE, 5, '0, 1'b0, '0);                 // never voted
      add_cmd(wca_pkg::CMD_LOAD, 10, 32'h7FFF_FFFF, 1'b0, '0);
      add_cmd(wca_pkg::CMD_LOAD, 11, 32'h8000_0000, 1'b1, '0);         // loaded as missing
      add_cmd(wca_pkg::CMD_READ, 10, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_READ, 11, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_READ, 63, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_READ + 3'd1, 0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);   // unused codes
      add_cmd(wca_pkg::CMD_READ + 3'd2, 1, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_READ + 3'd3, 2, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_CLEAR, 0, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_FINALIZE, 0, '0, 1'b0, '0);
      add_cmd(wca_pkg::CMD_READ, 1, '0, 1'b0, '0);
      add_hold(STEP_PAUSE, '0);

      // random phases, each under its own dims_in_use
      phase_dims[0] = 7'd1;
      phase_dims[1] = 7'd0;
      phase_dims[2] = 7'd127;
      phase_dims[3] = 7'd64;
      rnd = $urandom_range(2, 63);
      phase_dims[4] = rnd[wca_pkg::DIMS_W-1:0];
      rnd = $urandom_range(65, 126);
      phase_dims[5] = rnd[wca_pkg::DIMS_W-1:0];
      foreach (phase_dims[p]) begin
         add_hold(STEP_CSR, {25'd0, phase_dims[p]});
         repeat (100) add_random_cmd();
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (cmd_plan.size() != 0 || drv_state != DRV_IDLE || start ||
             center_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // driver: commands and csr writes, inputs change on the falling edge
   always @(negedge clock) begin : drive
      logic next_start;
      next_start = start;
      if (!reset) begin
         if (drv_state == DRV_START && req_taken) begin
            next_start = 1'b0;
            drv_state  = DRV_IDLE;
         end
         if (drv_state == DRV_ACCESS && csr_taken) begin
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            drv_state  = DRV_IDLE;
         end
         case (drv_state)
            DRV_IDLE: begin
               if (cmd_plan.size() != 0) begin
                  cur_step = cmd_plan.pop_front();
                  if (cur_step.kind != STEP_ITEM) begin
                     drv_state = DRV_DRAIN;
                  end else begin
                     // occasional stretches without gaps
                     if ($urandom_range(0, 31) == 0) no_gaps = !no_gaps;
                     gap_left = no_gaps ? 0 : int'($urandom_range(0, 15));
                     if (gap_left == 0) begin
                        next_start = 1'b1;
                        req_data  <= cur_step.item;
                        drv_state  = DRV_START;
                     end else begin
                        drv_state = DRV_GAP;
                     end
                  end
               end
            end
            DRV_GAP: begin
               gap_left--;
               if (gap_left == 0) begin
                  next_start = 1'b1;
                  req_data  <= cur_step.item;
                  drv_state  = DRV_START;
               end
            end
            // hold off until every pending center element has come out
            DRV_DRAIN: begin
               if (center_expected.size() == 0 && !busy) begin
                  if (cur_step.kind == STEP_CSR) begin
                     settle_left = SETTLE_CYCLES;
                     drv_state   = DRV_SETTLE;
                  end else begin
                     drv_state = DRV_IDLE;
                  end
               end
            end
            DRV_SETTLE: begin
               settle_left--;
               if (settle_left == 0) begin
                  psel     <= 1'b1;
                  pwrite   <= 1'b1;
                  paddr    <= DIMS_ADDR;
                  pwdata   <= cur_step.csr_value;
                  drv_state = DRV_SETUP;
               end
            end
            DRV_SETUP: begin
               penable  <= 1'b1;
               drv_state = DRV_ACCESS;
            end
            default: ;
         endcase
      end
      start <= next_start;
   end

   // monitor: result check, prediction on each command transfer, csr tracking
   always @(posedge clock) begin : observe
      wca_pkg::rsp_type want;
      wca_pkg::rsp_type emitted;
      req_taken <= start && !busy;
      csr_taken <= psel && penable && pwrite && pready;
      if (!reset) begin
         if (rsp_strobe) begin
            if (center_expected.size() == 0) begin
               $display("%0t: unexpected center element, expected none actual %h",
                        $time, rsp_data);
               error_count++;
            end else begin
               want = center_expected.pop_front();
               if (rsp_data.center_value !== want.center_value) begin
                  $display("%0t: center_value expected %h actual %h",
                           $time, want.center_value, rsp_data.center_value);
                  error_count++;
               end
               if (rsp_data.center_missing !== want.center_missing) begin
                  $display("%0t: center_missing expected %b actual %b",
                           $time, want.center_missing, rsp_data.center_missing);
                  error_count++;
               end
               if (rsp_data.out_dim !== want.out_dim) begin
                  $display("%0t: out_dim expected %0d actual %0d",
                           $time, want.out_dim, rsp_data.out_dim);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            if (predict_center(req_data, emitted)) center_expected.push_back(emitted);
         end
         if (psel && penable && pwrite && pready && paddr == DIMS_ADDR)
            dims_cfg = pwdata[wca_pkg::DIMS_W-1:0];
      end
   end

   // run limit
   initial begin
      drv_state   = DRV_IDLE;
      no_gaps     = 1'b0;
      gap_left    = 0;
      settle_left = 0;
      error_count = 0;
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached", $time);
         $display("simulation failed");
         $finish;
      end
   end

endmodule

FILE: filelist.f
src/wca_pkg.sv
src/wca_datapath.sv
src/wca_ctrl.sv
src/weighted_centroid_accumulator.sv
dv/testbench.sv
